[hw/rtl/swm_pkg.sv]
// Shared types and constants for the sliding window maximum block.
`default_nettype none

package swm_pkg;

    // Width of one sample and of the window size register.
    localparam int SAMPLE_W = 32;
    localparam int WINDOW_W = 7;

    // Window size after reset.
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Control that the top level broadcasts to every cell of the chain.
    typedef struct packed {
        logic step;     // a sample word is taken in this cycle
        logic restart;  // the sample opens a new stream
        logic shift;    // the front entry leaves; each cell takes its right neighbor
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/sliding_window_maximum.sv]
// Latency: once a stream holds a full window, a result word is shown in the cycle after its
// sample word is accepted. Throughput: one sample word per cycle while results are taken and
// no pruning pass runs; every cell compares in parallel. After a window size write, a pruning
// pass drops, one per cycle, the entries that have grown too old for the new size; it holds
// off sample words until the front entry is no longer too old.
// Reset clears the deque, the stream state and the result valid flag, and sets the window to one.
`default_nettype none

module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sample_t             sample,
    input  wire logic                first,
    input  wire logic                last,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output sample_t                  window_max,
    output logic                     final_window,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire logic [WINDOW_W-1:0] cfg_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (KW > WINDOW_W) ? KW : WINDOW_W;
    localparam logic [KW-1:0] FILL_MAX = '1;

    logic [WINDOW_W-1:0] window_size_reg;
    logic                clean_reg;
    logic                clean_next;
    logic                stream_ended_reg;
    logic [KW-1:0]       fill_reg;
    logic [KW-1:0]       fill_base;
    logic [KW-1:0]       fill_next;
    logic                out_valid_reg;
    sample_t             window_max_reg;
    logic                final_window_reg;

    logic [CW-1:0]       ws_ext;
    logic [KW-1:0]       keff;
    logic [AW-1:0]       kminus1;
    logic                accept;
    logic                cfg_write;
    logic                restart;
    logic                front_expired;
    logic                result_hit;
    cell_ctrl_t          ctrl;

    logic                cell_valid      [MAX_WINDOW];
    sample_t             cell_value      [MAX_WINDOW];
    logic [AW-1:0]       cell_age        [MAX_WINDOW];
    logic                cell_keep       [MAX_WINDOW];
    logic                cell_src_keep   [MAX_WINDOW];
    sample_t             cell_value_next [MAX_WINDOW];

    // Effective window: zero counts as one, oversize clamps to the cell count.
    assign ws_ext = CW'(window_size_reg);
    always_comb
    begin
        if (ws_ext == '0)
        begin
            keff = KW'(1);
        end
        else if (ws_ext > CW'(MAX_WINDOW))
        begin
            keff = KW'(MAX_WINDOW);
        end
        else
        begin
            keff = KW'(ws_ext);
        end
    end
    assign kminus1 = AW'(keff - KW'(1));

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_ready  = !clean_reg && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign restart   = first || stream_ended_reg;

    // Only the front entry can reach the window age on a sample; the pruning
    // pass after a size change removes any others one per cycle.
    assign front_expired = cell_valid[0] && (cell_age[0] >= kminus1);
    assign clean_next    = cfg_write || (clean_reg && front_expired);

    always_comb
    begin
        ctrl.step    = accept;
        ctrl.restart = restart;
        ctrl.shift   = front_expired && (accept || clean_reg);
    end

    // Samples seen in the current stream, saturating.
    assign fill_base  = restart ? '0 : fill_reg;
    assign fill_next  = (fill_base == FILL_MAX) ? fill_base : fill_base + KW'(1);
    assign result_hit = fill_next >= keff;

    // The chain of cells, front entry in cell zero.
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic          right_valid;
        sample_t       right_value;
        logic [AW-1:0] right_age;
        logic          right_keep;
        logic          left_src_keep;

        if (i == MAX_WINDOW - 1)
        begin : g_end
            assign right_valid = 1'b0;
            assign right_value = '0;
            assign right_age   = '0;
            assign right_keep  = 1'b0;
        end
        else
        begin : g_mid
            assign right_valid = cell_valid[i+1];
            assign right_value = cell_value[i+1];
            assign right_age   = cell_age[i+1];
            assign right_keep  = cell_keep[i+1];
        end

        if (i == 0)
        begin : g_front
            assign left_src_keep = 1'b1;
        end
        else
        begin : g_back
            assign left_src_keep = cell_src_keep[i-1];
        end

        swm_cell #(
            .AGE_W(AW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .sample       (sample),
            .right_valid  (right_valid),
            .right_value  (right_value),
            .right_age    (right_age),
            .right_keep   (right_keep),
            .left_src_keep(left_src_keep),
            .valid        (cell_valid[i]),
            .value        (cell_value[i]),
            .age          (cell_age[i]),
            .keep         (cell_keep[i]),
            .src_keep     (cell_src_keep[i]),
            .value_next   (cell_value_next[i])
        );
    end

    // Control and stream state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= WINDOW_RESET;
            clean_reg        <= 1'b0;
            stream_ended_reg <= 1'b0;
            fill_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clean_reg <= clean_next;
            if (cfg_write)
            begin
                window_size_reg <= cfg_data;
            end
            if (accept)
            begin
                stream_ended_reg <= last;
                fill_reg         <= fill_next;
                out_valid_reg    <= result_hit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word: the new front of the deque.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_max_reg   <= cell_value_next[0];
            final_window_reg <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign window_max   = window_max_reg;
    assign final_window = final_window_reg;

endmodule

`default_nettype wire

[hw/rtl/swm_cell.sv]
// One cell of the monotonic deque chain: holds one entry and its age.
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int AGE_W = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire sample_t          sample,
    input  wire logic             right_valid,
    input  wire sample_t          right_value,
    input  wire logic [AGE_W-1:0] right_age,
    input  wire logic             right_keep,
    input  wire logic             left_src_keep,
    output logic                  valid,
    output sample_t               value,
    output logic [AGE_W-1:0]      age,
    output logic                  keep,
    output logic                  src_keep,
    output sample_t               value_next
);

    logic             valid_reg;
    logic             valid_next;
    sample_t          value_reg;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    sample_t          src_value;
    logic [AGE_W-1:0] src_age;

    // An entry survives a new sample unless the sample is strictly larger.
    assign keep = valid_reg && (value_reg >= sample);

    // The entry that lands here comes from this cell or, on a shift, from the right.
    assign src_value = ctrl.shift ? right_value : value_reg;
    assign src_age   = ctrl.shift ? right_age : age_reg;
    assign src_keep  = !ctrl.restart && (ctrl.shift ? right_keep : keep);

    // Next entry: kept entry ages by one; the first free slot takes the sample; a shift alone takes the right entry.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.step)
        begin
            if (src_keep)
            begin
                valid_next = 1'b1;
                value_next = src_value;
                age_next   = src_age + AGE_W'(1);
            end
            else if (left_src_keep)
            begin
                valid_next = 1'b1;
                value_next = sample;
                age_next   = '0;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = right_valid;
            value_next = right_value;
            age_next   = right_age;
        end
    end

    // Occupancy flag is control state; value and age are payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

`default_nettype wire

[hw/rtl/swm_checker.sv]
// Port-level checks for the sliding window maximum block, bound to the top level.
`default_nettype none

module swm_checker
    import swm_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire sample_t window_max,
    input wire logic    final_window,
    input wire logic    cfg_valid,
    input wire logic    cfg_ready
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(window_max) && $stable(final_window))
        else $error("result word changed while stalled");

    // A new result word only follows an accepted sample word.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result word without a sample word");

    // No sample word is taken while a result word is stuck.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("sample word accepted over a stalled result");

    // A window size write starts the pruning pass, which blocks input.
    a_cfg_prune: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input open right after a window size write");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_max  (window_max),
    .final_window(final_window),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);

`default_nettype wire
